/* hw/rtl/stftw_pkg.sv */
// stftw_pkg: shared widths and codes for the stft frame window dft block
// no dependencies; imported by the ram, the top level and the bench
`timescale 1ns / 1ps

package stftw_pkg;

    // input item kinds (tuser)
    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // register index of hop_size
    localparam logic REG_HOP = 1'b0;

    localparam int SAMPLE_W = 16;
    localparam int X_W      = 17;   // windowed sample, rounded
    localparam int TW_W     = 17;   // q1.15 twiddle with sign
    localparam int BIN_W    = 24;
    localparam int HOP_W    = 7;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [BIN_W-1:0]    t_bin;

endpackage

/* hw/rtl/stftw_ram.sv */
// stftw_ram: generic single write, single read memory with registered read
// depends on stftw_pkg: imports it, though it uses none of its names
`timescale 1ns / 1ps

module stftw_ram
    import stftw_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/stft_frame_window_dft.sv */
// stft_frame_window_dft: sample ring, loaded window and direct dft per frame
// depends on stftw_pkg and stftw_ram (sample ring and window table)
`timescale 1ns / 1ps

// channel   direction  transfer
// s_axis    in         tuser=command, tdata={value, coef_index}
// m_axis    out        tdata={bin_imag, bin_real, bin_index}, tlast=last_bin
// apb       in/out     hop_size at byte address 0
//
// a coefficient write or a sample that takes no frame leaves the block idle and ready
// a frame gives FFT_SIZE/2+1 bins; each bin is one pass over the ring,
// one ring read and one window read a cycle through a single mac chain
// input is held off (s_axis_tready low) while a frame is in progress
// a stalled result holds the engine in its emit step; the output register
// lets the next item in while the last bin still waits
// synchronous active-low reset clears control; both memories start undefined

module stft_frame_window_dft
    import stftw_pkg::*;
#(
    parameter int FFT_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample / coefficient stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [5:0] coef_index, [21:6] value, zero pad
    input  logic        s_axis_tuser,   // [0] command
    // bin stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [5:0] bin_index, [29:6] bin_real,
                                        // [53:30] bin_imag, zero pad
    output logic        m_axis_tlast,   // last_bin
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = $clog2(FFT_SIZE);
    localparam int CW     = $clog2(FFT_SIZE + 1);
    localparam int NBINS  = FFT_SIZE / 2 + 1;
    localparam int KW     = $clog2(NBINS);
    localparam int PR_W   = X_W + TW_W;
    localparam int ACC_W  = PR_W + AW;
    localparam int Q_W    = ACC_W - 14;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    typedef logic signed [TW_W-1:0] t_tw_tab [FFT_SIZE];

    // shift and subtract divide, only evaluated while the tables are built
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q, rm;
        q  = '0;
        rm = '0;
        for (int i = 63; i >= 0; i--) begin
            rm = {rm[62:0], num[i]};
            if (rm >= den) begin
                rm   = rm - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // q1.15 twiddle, same fixed-point series as the bench's make_twiddle
    function automatic logic signed [TW_W-1:0] tw_q15(input int unsigned mi,
                                                      input bit want_sin);
        logic [63:0] x, x2, ts, tc, ds, dc;
        logic signed [63:0] s, c, t, va, vb;
        int unsigned m, quad, rem, r;
        bit swap;
        logic signed [TW_W-1:0] a, b, res;
        m    = mi % FFT_SIZE;
        quad = (4 * m) / FFT_SIZE;
        rem  = 4 * m - quad * FFT_SIZE;
        swap = (2 * rem) > FFT_SIZE;
        r    = swap ? FFT_SIZE - rem : rem;
        x    = (64'd3373259426 * 64'(r) + 64'(FFT_SIZE / 2)) / 64'(FFT_SIZE);
        x2   = (x * x) >> 31;
        s    = $signed(x);
        c    = 64'sd2147483648;
        ts   = x;
        tc   = 64'd2147483648;
        for (int i = 0; i < 12; i++) begin
            ds = 64'((2 * i + 2) * (2 * i + 3));
            dc = 64'((2 * i + 1) * (2 * i + 2));
            ts = udiv64((ts * x2) >> 31, ds);
            tc = udiv64((tc * x2) >> 31, dc);
            if (i % 2 == 1) begin
                s = s + $signed(ts);
                c = c + $signed(tc);
            end else begin
                s = s - $signed(ts);
                c = c - $signed(tc);
            end
        end
        if (swap) begin
            t = s;
            s = c;
            c = t;
        end
        va = (c < 0) ? 64'sd0 : ((c > 64'sd2147483648) ? 64'sd2147483648 : c);
        vb = (s < 0) ? 64'sd0 : ((s > 64'sd2147483648) ? 64'sd2147483648 : s);
        va = (va + 64'sd32768) >>> 16;
        vb = (vb + 64'sd32768) >>> 16;
        if (va > 64'sd32767) va = 64'sd32767;
        if (vb > 64'sd32767) vb = 64'sd32767;
        a = TW_W'(va);
        b = TW_W'(vb);
        case (quad % 4)
            0:       res = want_sin ? b  : a;
            1:       res = want_sin ? a  : -b;
            2:       res = want_sin ? -b : -a;
            default: res = want_sin ? -a : b;
        endcase
        return res;
    endfunction

    function automatic t_tw_tab build_tab(input bit want_sin);
        t_tw_tab tab;
        for (int m = 0; m < FFT_SIZE; m++) begin
            tab[m] = tw_q15(m, want_sin);
        end
        return tab;
    endfunction

    localparam t_tw_tab COS_TAB = build_tab(1'b0);
    localparam t_tw_tab SIN_TAB = build_tab(1'b1);

    // input field unpacking
    logic              in_cmd;
    logic [5:0]        in_idx;
    t_sample           in_val;
    logic              in_acc;
    assign in_cmd = s_axis_tuser;
    assign in_idx = s_axis_tdata[5:0];
    assign in_val = s_axis_tdata[21:6];

    // control state
    logic [1:0]        r_state, n_state;
    logic [HOP_W-1:0]  r_hop;
    logic [AW-1:0]     r_wp, n_wp;
    logic [CW-1:0]     r_fill, n_fill;
    logic [HOP_W-1:0]  r_cd, n_cd;
    logic [AW-1:0]     r_base, n_base;
    logic [KW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_j, n_j;
    logic [AW-1:0]     r_ra, n_ra;
    logic [AW-1:0]     r_m, n_m;
    logic              take;
    logic              start_bin;
    logic              out_free;
    logic              emit;

    // pipeline
    logic              r_v1, r_v2, r_v3, r_v4;
    logic              r_l1, r_l2, r_l3, r_l4;
    logic [AW-1:0]     r_m1, r_m2;
    logic signed [31:0]        r_p2;
    logic signed [X_W-1:0]     r_x3;
    logic signed [TW_W-1:0]    r_c3, r_s3;
    logic signed [PR_W-1:0]    r_pr4, r_pi4;
    logic signed [ACC_W-1:0]   r_acc_re, r_acc_im;
    logic                      r_acc_done;
    logic signed [32:0]        x_sum;

    // output register
    logic              r_out_valid;
    logic [KW-1:0]     r_out_k;
    t_bin              r_out_re, r_out_im;
    logic              r_out_last;
    t_bin              round_re, round_im;

    // memories
    logic [SAMPLE_W-1:0] ring_rdata, win_rdata;
    logic                ring_we, win_we;
    logic [SAMPLE_W-1:0] win_wdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign ring_we       = in_acc && (in_cmd == CMD_SAMPLE);
    assign win_we        = in_acc && (in_cmd == CMD_COEF) && (7'(in_idx) < 7'(FFT_SIZE));
    assign win_wdata     = in_val[SAMPLE_W-1] ? '0 : in_val;

    stftw_ram #(.WIDTH(SAMPLE_W), .DEPTH(FFT_SIZE)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (in_val),
        .i_re    (r_state == S_RUN),
        .i_raddr (r_ra),
        .o_rdata (ring_rdata)
    );

    stftw_ram #(.WIDTH(SAMPLE_W), .DEPTH(FFT_SIZE)) u_win (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (in_idx[AW-1:0]),
        .i_wdata (win_wdata),
        .i_re    (r_state == S_RUN),
        .i_raddr (r_j),
        .o_rdata (win_rdata)
    );

    // frame trigger: first full ring, then every hop samples (a zero hop acts as one)
    always_comb begin
        n_wp   = r_wp;
        n_fill = r_fill;
        n_cd   = r_cd;
        take   = 1'b0;
        if (ring_we) begin
            n_wp = (r_wp == AW'(FFT_SIZE - 1)) ? '0 : r_wp + 1'b1;
            if (r_fill < CW'(FFT_SIZE)) begin
                n_fill = r_fill + 1'b1;
                take   = (n_fill == CW'(FFT_SIZE));
            end else if (r_cd <= HOP_W'(1)) begin
                take = 1'b1;
            end else begin
                n_cd = r_cd - 1'b1;
            end
            if (take) begin
                n_cd = (r_hop == '0) ? HOP_W'(1) : r_hop;
            end
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;
    assign emit     = (r_state == S_EMIT) && r_acc_done && out_free;

    // sequencer: one bin per pass over the ring
    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_k       = r_k;
        n_j       = r_j;
        n_ra      = r_ra;
        n_m       = r_m;
        start_bin = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_base    = n_wp;
                    n_k       = '0;
                    start_bin = 1'b1;
                end
            end
            S_RUN: begin
                n_j  = r_j + 1'b1;
                n_ra = (r_ra == AW'(FFT_SIZE - 1)) ? '0 : r_ra + 1'b1;
                if ({1'b0, r_m} + {1'b0, AW'(r_k)} >= (AW+1)'(FFT_SIZE)) begin
                    n_m = AW'({1'b0, r_m} + {1'b0, AW'(r_k)} - (AW+1)'(FFT_SIZE));
                end else begin
                    n_m = r_m + AW'(r_k);
                end
                if (r_j == AW'(FFT_SIZE - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit) begin
                    if (r_k == KW'(NBINS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k       = r_k + 1'b1;
                        start_bin = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (start_bin) begin
            n_state = S_RUN;
            n_j     = '0;
            n_ra    = (r_state == S_IDLE) ? n_wp : r_base;
            n_m     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hop       <= HOP_W'(16);
            r_wp        <= '0;
            r_fill      <= '0;
            r_cd        <= '0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_acc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            r_cd    <= n_cd;
            r_k     <= n_k;
            if (psel && penable && pwrite && (paddr[2] == REG_HOP)) begin
                r_hop <= pwdata[HOP_W-1:0];
            end
            r_v1 <= (r_state == S_RUN);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (start_bin) begin
                r_acc_done <= 1'b0;
            end else if (r_v4 && r_l4) begin
                r_acc_done <= 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    assign x_sum = {r_p2[31], r_p2} + 33'sd16384;

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_j    <= n_j;
        r_ra   <= n_ra;
        r_m    <= n_m;
        // stage 1: memory read in flight
        r_m1 <= r_m;
        r_l1 <= (r_j == AW'(FFT_SIZE - 1));
        // stage 2: window product
        r_p2 <= $signed(ring_rdata) * $signed(win_rdata);
        r_m2 <= r_m1;
        r_l2 <= r_l1;
        // stage 3: round to integer, fetch twiddles
        r_x3 <= x_sum[31:15];
        r_c3 <= COS_TAB[r_m2];
        r_s3 <= SIN_TAB[r_m2];
        r_l3 <= r_l2;
        // stage 4: twiddle products
        r_pr4 <= r_x3 * r_c3;
        r_pi4 <= r_x3 * r_s3;
        r_l4  <= r_l3;
        // stage 5: accumulate
        if (start_bin) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v4) begin
            r_acc_re <= r_acc_re + ACC_W'(r_pr4);
            r_acc_im <= r_acc_im - ACC_W'(r_pi4);
        end
        if (emit) begin
            r_out_k    <= r_k;
            r_out_re   <= round_re;
            r_out_im   <= round_im;
            r_out_last <= (r_k == KW'(NBINS - 1));
        end
    end

    // round to nearest (ties up) and saturate to 24 bits
    function automatic t_bin round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W:0]  sum;
        logic signed [Q_W-1:0]  q;
        t_bin                   res;
        sum = {v[ACC_W-1], v} + (ACC_W+1)'(16384);
        q   = sum[ACC_W:15];
        if (q > Q_W'(8388607)) begin
            res = 24'sh7FFFFF;
        end else if (q < -Q_W'(8388608)) begin
            res = 24'sh800000;
        end else begin
            res = q[BIN_W-1:0];
        end
        return res;
    endfunction

    assign round_re = round_sat(r_acc_re);
    assign round_im = round_sat(r_acc_im);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_im, r_out_re, 6'(r_out_k)};
    assign m_axis_tlast  = r_out_last;

    assign prdata = (paddr[2] == REG_HOP) ? {{(32-HOP_W){1'b0}}, r_hop} : 32'd0;
    assign pready = 1'b1;

`ifndef NO_ASSERTIONS
    // a frame only starts on a full ring
    a_frame_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_RUN) |=> (r_fill == CW'(FFT_SIZE)))
        else $error("frame started before the ring was full");

    // a bin is emitted only after its last term reached the accumulator
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (r_acc_done && !r_v1 && !r_v2 && !r_v3 && !r_v4))
        else $error("bin emitted with terms still in flight");

    // bin counter stays within the half spectrum
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(NBINS - 1))
        else $error("bin counter out of range");

    // tlast marks exactly the top bin
    a_last_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (r_out_k == KW'(NBINS - 1))))
        else $error("last_bin does not match bin index");
`endif

endmodule

/* verif/stft_frame_window_dft_test.sv */
// stft_frame_window_dft_test: self-checking bench for the stft frame window dft block
// depends on stftw_pkg and the stft_frame_window_dft rtl; predicts every bin in-bench
`timescale 1ns / 1ps

module stft_frame_window_dft_test;
    import stftw_pkg::*;

    localparam int N      = 64;
    localparam int NBINS  = N / 2 + 1;

    typedef struct {
        logic [5:0]        idx;
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic              last;
    } t_bin_exp;

    typedef struct {
        logic              cmd;
        logic [5:0]        idx;
        logic signed [15:0] val;
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stft_frame_window_dft #(.FFT_SIZE(N)) DUT (.*);

    // predictor state, mirrors the ring, window and frame scheduling
    logic [15:0] ring_mem [N];
    logic [15:0] win_mem  [N];
    int          ring_wp;
    int          ring_fill;
    int          hop_left;
    int          hop_reg;
    int          cos_q [N];
    int          sin_q [N];

    t_bin_exp    bins_due [$];
    int          errors;
    int          hold_cycles;   // long receiver hold-off, counted by the receiver
    bit          no_gaps;       // stretch with no idling on either side

    // ------------------------------------------------------------------
    // q1.15 twiddles from a fixed-point taylor series in q31
    // ------------------------------------------------------------------
    function automatic int q31_to_q15(longint v);
        longint q;
        if (v < 0) v = 0;
        if (v > 64'sd2147483648) v = 64'sd2147483648;
        q = (v + 32768) >>> 16;
        if (q > 32767) q = 32767;
        return int'(q);
    endfunction

    function automatic void make_twiddle(input int m, output int cq, output int sq);
        longint unsigned quad, rem, r, x, x2, ts, tc, ds, dc;
        longint          s, c, t;
        bit              swap;
        int              a, b;
        quad = (4 * m) / N;
        rem  = 4 * m - quad * N;
        swap = (2 * rem) > N;
        r    = swap ? N - rem : rem;
        x    = (64'd3373259426 * r + N / 2) / N;
        x2   = (x * x) >> 31;
        s    = longint'(x);
        c    = 64'sd2147483648;
        ts   = x;
        tc   = 64'd2147483648;
        for (int i = 0; i < 12; i++) begin
            ds = (2 * i + 2) * (2 * i + 3);
            dc = (2 * i + 1) * (2 * i + 2);
            ts = ((ts * x2) >> 31) / ds;
            tc = ((tc * x2) >> 31) / dc;
            if (i % 2 == 1) begin
                s += longint'(ts);
                c += longint'(tc);
            end else begin
                s -= longint'(ts);
                c -= longint'(tc);
            end
        end
        if (swap) begin
            t = s;
            s = c;
            c = t;
        end
        a = q31_to_q15(c);
        b = q31_to_q15(s);
        case (quad % 4)
            0: begin cq = a;  sq = b;  end
            1: begin cq = -b; sq = a;  end
            2: begin cq = -a; sq = -b; end
            default: begin cq = b; sq = -a; end
        endcase
    endfunction

    // round to nearest (ties up) from q15 scale, saturated to 24 bits
    function automatic logic signed [23:0] round_bin(longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 8388607)  r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    // windowed frame, oldest sample first, then bins 0..N/2
    task automatic queue_frame_bins();
        longint   xw [N];
        longint   re, im;
        t_bin_exp e;
        for (int j = 0; j < N; j++)
            xw[j] = (longint'($signed(ring_mem[(ring_wp + j) % N])) *
                     longint'($signed(win_mem[j])) + 16384) >>> 15;
        for (int k = 0; k < NBINS; k++) begin
            re = 0;
            im = 0;
            for (int j = 0; j < N; j++) begin
                re += xw[j] * cos_q[(k * j) % N];
                im -= xw[j] * sin_q[(k * j) % N];
            end
            e.idx  = k[5:0];
            e.re   = round_bin(re);
            e.im   = round_bin(im);
            e.last = (k == NBINS - 1);
            bins_due = {bins_due, e};
        end
    endtask

    // one accepted input transfer
    task automatic predict_item(t_item it);
        bit take;
        if (it.cmd == CMD_COEF) begin
            // negative coefficients are stored as zero
            win_mem[it.idx] = it.val[15] ? 16'd0 : it.val;
            return;
        end
        ring_mem[ring_wp] = it.val;
        ring_wp = (ring_wp + 1) % N;
        take = 0;
        if (ring_fill < N) begin
            ring_fill++;
            take = (ring_fill == N);
        end else if (hop_left <= 1) begin
            take = 1;
        end else begin
            hop_left--;
        end
        if (take) begin
            // zero hop behaves as one
            hop_left = (hop_reg == 0) ? 1 : hop_reg;
            queue_frame_bins();
        end
    endtask

    // ------------------------------------------------------------------
    // clock, run limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("stft_frame_window_dft_test failed");
        $finish;
    end

    function automatic int gap_len();
        int p;
        if (no_gaps) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // ------------------------------------------------------------------
    // bin receiver: random stalls plus the long hold-off
    // ------------------------------------------------------------------
    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready = 0;
                hold_cycles--;
            end else if (no_gaps) begin
                m_axis_tready = 1;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) < 70) ||
                                ($urandom_range(0, 99) < 5 ? 0 : 0);
                if (!m_axis_tready && $urandom_range(0, 19) == 0)
                    hold_cycles = $urandom_range(10, 80);
            end
        end
    end

    // result check on every accepted bin transfer
    always @(posedge i_clk) begin
        t_bin_exp e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (bins_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected bin transfer: tdata=%h tlast=%b",
                             m_axis_tdata, m_axis_tlast);
            end else begin
                e = bins_due.pop_front();
                if (m_axis_tdata[5:0] !== e.idx || m_axis_tdata[29:6] !== e.re ||
                    m_axis_tdata[53:30] !== e.im || m_axis_tlast !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("bin mismatch: exp k=%0d re=%0d im=%0d last=%b, got k=%0d re=%0d im=%0d last=%b",
                                 e.idx, e.re, e.im, e.last, m_axis_tdata[5:0],
                                 $signed(m_axis_tdata[29:6]), $signed(m_axis_tdata[53:30]),
                                 m_axis_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sender and register access
    // ------------------------------------------------------------------
    task automatic send_item(t_item it);
        int g;
        @(negedge i_clk);
        s_axis_tvalid = 1;
        s_axis_tuser  = it.cmd;
        s_axis_tdata  = {2'b00, it.val, it.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(it);
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        s_axis_tvalid = 0;
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel = 1; pwrite = 1; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic apb_check(logic [2:0] addr, logic [31:0] want);
        @(negedge i_clk);
        psel = 1; pwrite = 0; paddr = addr;
        @(negedge i_clk);
        penable = 1;
        do @(posedge i_clk); while (!pready);
        if (prdata[HOP_W-1:0] !== want[HOP_W-1:0]) begin
            errors++;
            if (errors <= 10)
                $display("register read mismatch: exp %0d got %0d", want, prdata);
        end
        @(negedge i_clk);
        psel = 0; penable = 0;
    endtask

    // only while idle: all bins back, then a short settle
    task automatic set_hop(int h);
        drop_valid();
        wait (bins_due.size() == 0);
        repeat (N + 8) @(posedge i_clk);
        apb_write(3'(REG_HOP) << 2, h);
        hop_reg = h;
        apb_check(3'(REG_HOP) << 2, h);
    endtask

    function automatic t_item rand_item(int coef_pct);
        t_item it;
        it.cmd = ($urandom_range(0, 99) < coef_pct) ? CMD_COEF : CMD_SAMPLE;
        it.idx = $urandom_range(0, N - 1);
        case ($urandom_range(0, 9))
            0: it.val = 16'sh7fff;
            1: it.val = 16'sh8000;
            2: it.val = $urandom_range(0, 15) - 8;
            default: it.val = $urandom;
        endcase
        return it;
    endfunction

    task automatic random_run(int count, int coef_pct);
        for (int i = 0; i < count; i++)
            send_item(rand_item(coef_pct));
    endtask

    // directed rows: extremes of every field, both commands, negative coefficients
    t_item directed_rows [20] = '{
        '{CMD_COEF,   6'd0,  16'sh7fff},
        '{CMD_COEF,   6'd63, 16'sh0000},
        '{CMD_COEF,   6'd5,  16'shffff},   // negative coefficient, stored as zero
        '{CMD_COEF,   6'd6,  16'sh8000},   // most negative coefficient
        '{CMD_COEF,   6'd42, 16'sh4000},
        '{CMD_COEF,   6'd21, 16'sh2aaa},
        '{CMD_SAMPLE, 6'd0,  16'sh7fff},
        '{CMD_SAMPLE, 6'd63, 16'sh8000},
        '{CMD_SAMPLE, 6'd0,  16'sh0000},
        '{CMD_SAMPLE, 6'd0,  16'shffff},
        '{CMD_SAMPLE, 6'd0,  16'sh0001},
        '{CMD_SAMPLE, 6'd21, 16'sh5555},
        '{CMD_SAMPLE, 6'd42, 16'shaaaa},
        '{CMD_SAMPLE, 6'd0,  16'sh7fff},
        '{CMD_SAMPLE, 6'd0,  16'sh7fff},
        '{CMD_SAMPLE, 6'd0,  16'sh8000},
        '{CMD_SAMPLE, 6'd0,  16'sh8000},
        '{CMD_SAMPLE, 6'd0,  16'sh4000},
        '{CMD_SAMPLE, 6'd0,  16'shc000},
        '{CMD_COEF,   6'd63, 16'sh7fff}
    };

    initial begin
        t_item it;
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        errors = 0; hold_cycles = 0; no_gaps = 0;
        ring_wp = 0; ring_fill = 0; hop_left = 0; hop_reg = 16;
        for (int i = 0; i < N; i++) begin
            ring_mem[i] = '0;
            win_mem[i]  = '0;
            make_twiddle(i, cos_q[i], sin_q[i]);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // hop reads back its reset value
        apb_check(3'(REG_HOP) << 2, 16);

        // load every window entry before any frame can read it
        no_gaps = 1;
        for (int i = 0; i < N; i++) begin
            it.cmd = CMD_COEF;
            it.idx = i;
            it.val = $urandom_range(0, 32767);
            send_item(it);
        end
        no_gaps = 0;

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        // default hop: first frame, then frames every sixteen samples
        random_run(70, 8);

        // shortest hop: a frame per sample; long receiver hold-off fills the block
        set_hop(1);
        hold_cycles = 3000;
        random_run(20, 5);
        drop_valid();
        wait (bins_due.size() == 0);

        // hop equal to the frame size, with a run free of idling
        set_hop(64);
        no_gaps = 1;
        random_run(30, 5);
        no_gaps = 0;
        random_run(40, 10);

        // zero hop acts as one
        set_hop(0);
        random_run(12, 10);

        set_hop(7);
        random_run(24, 10);

        drop_valid();
        wait (bins_due.size() == 0);
        repeat (2 * N * NBINS) @(posedge i_clk);
        if (errors == 0) begin
            $display("stft_frame_window_dft_test passed");
        end else begin
            $display("stft_frame_window_dft_test failed");
        end
        $finish;
    end

endmodule

/* stft_frame_window_dft.f */
hw/rtl/stftw_pkg.sv
hw/rtl/stftw_ram.sv
hw/rtl/stft_frame_window_dft.sv
verif/stft_frame_window_dft_test.sv
